>>> rtl/core/tmr_pkg.sv
// Shared types and constants of the trackball motion to report block.
package tmr_pkg;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SCROLL_DIVIDER = 2'd0;
    localparam t_cfg_idx CFG_SNAP_MODE      = 2'd1;
    localparam t_cfg_idx CFG_LEFT_HALF      = 2'd2;

    localparam logic OP_MOTION = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [1:0] SNAP_VERTICAL   = 2'd0;
    localparam logic [1:0] SNAP_HORIZONTAL = 2'd1;

    localparam logic [2:0] DIV_DEFAULT = 3'd4;

    localparam logic signed [15:0] SAT_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN  = 16'sh8000;
    localparam logic signed [7:0]  CLIP_MAX = 8'sd127;
    localparam logic signed [7:0]  CLIP_MIN = -8'sd127;

    typedef struct packed {
        logic [2:0] scroll_divider;
        logic [1:0] snap_mode;
        logic       left_half;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic               scroll_active;
    } t_item;

    typedef struct packed {
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic signed [7:0] wheel_h;
        logic signed [7:0] wheel_v;
    } t_report;

endpackage

>>> rtl/core/tmr_in_if.sv
// Input channel carrying motion deltas and report requests.
interface tmr_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               scroll_active;

    modport source (output valid, output opcode, output delta_x, output delta_y,
                    output scroll_active, input ready);
    modport sink (input valid, input opcode, input delta_x, input delta_y,
                  input scroll_active, output ready);
endinterface

>>> rtl/core/tmr_out_if.sv
// Output channel carrying mouse reports.
interface tmr_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_h;
    logic signed [7:0] wheel_v;

    modport source (output valid, output move_x, output move_y, output wheel_h,
                    output wheel_v, input ready);
    modport sink (input valid, input move_x, input move_y, input wheel_h,
                  input wheel_v, output ready);
endinterface

>>> rtl/core/tmr_cfg_regs.sv
// Configuration register file of the trackball motion to report block.
module tmr_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  tmr_pkg::t_cfg_idx i_cfg_idx,
    input  logic [2:0]       i_cfg_data,
    output tmr_pkg::t_cfg    o_cfg
);
    import tmr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCROLL_DIVIDER: n_cfg.scroll_divider = i_cfg_data;
                CFG_SNAP_MODE:      n_cfg.snap_mode = i_cfg_data[1:0];
                CFG_LEFT_HALF:      n_cfg.left_half = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scroll_divider <= DIV_DEFAULT;
            r_cfg.snap_mode      <= SNAP_VERTICAL;
            r_cfg.left_half      <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> rtl/core/tmr_report_core.sv
// Motion accumulators and report forming logic.
module tmr_report_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  tmr_pkg::t_item   i_item,
    input  tmr_pkg::t_cfg    i_cfg,
    output tmr_pkg::t_report o_report
);
    import tmr_pkg::*;

    logic signed [15:0] r_accum_x;
    logic signed [15:0] r_accum_y;
    logic signed [15:0] n_accum_x;
    logic signed [15:0] n_accum_y;
    logic [2:0]         shift;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [7:0]  cx;
    logic signed [7:0]  cy;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            return s[16] ? SAT_MIN : SAT_MAX;
        end
        return s[15:0];
    endfunction

    function automatic logic signed [7:0] clip8(input logic signed [15:0] v);
        if (v > 16'sd127) begin
            return CLIP_MAX;
        end
        if (v < -16'sd127) begin
            return CLIP_MIN;
        end
        return v[7:0];
    endfunction

    // Arithmetic shift with a bias on negative values truncates toward zero.
    function automatic logic signed [15:0] div_trunc(input logic signed [15:0] a,
                                                     input logic [2:0] s);
        logic [16:0]        bias;
        logic signed [16:0] t;
        bias = a[15] ? ((17'd1 << s) - 17'd1) : 17'd0;
        t = {a[15], a} + $signed(bias);
        return 16'(t >>> s);
    endfunction

    function automatic logic signed [15:0] rem_of(input logic signed [15:0] a,
                                                  input logic signed [15:0] q,
                                                  input logic [2:0] s);
        logic signed [16:0] r;
        r = {a[15], a} - ({q[15], q} <<< s);
        return r[15:0];
    endfunction

    always_comb begin
        shift = ((i_cfg.scroll_divider == 3'd0) ? DIV_DEFAULT : i_cfg.scroll_divider) - 3'd1;
        qx = div_trunc(r_accum_x, shift);
        qy = div_trunc(r_accum_y, shift);
        cx = clip8(qx);
        cy = clip8(qy);

        n_accum_x = r_accum_x;
        n_accum_y = r_accum_y;
        o_report  = '0;

        if (i_item.opcode == OP_MOTION) begin
            n_accum_x = sat_add(r_accum_x, i_item.delta_x);
            n_accum_y = sat_add(r_accum_y, i_item.delta_y);
        end else if (!i_item.scroll_active) begin
            o_report.move_x = i_cfg.left_half ? -clip8(r_accum_y) : clip8(r_accum_y);
            o_report.move_y = i_cfg.left_half ? -clip8(r_accum_x) : clip8(r_accum_x);
            n_accum_x = '0;
            n_accum_y = '0;
        end else begin
            n_accum_x = rem_of(r_accum_x, qx, shift);
            n_accum_y = rem_of(r_accum_y, qy, shift);
            o_report.wheel_h = i_cfg.left_half ? cy : -cy;
            o_report.wheel_v = i_cfg.left_half ? -cx : cx;
            case (i_cfg.snap_mode)
                SNAP_VERTICAL:   o_report.wheel_h = '0;
                SNAP_HORIZONTAL: o_report.wheel_v = '0;
                default:         o_report.wheel_h = o_report.wheel_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum_x <= '0;
            r_accum_y <= '0;
        end else if (i_fire) begin
            r_accum_x <= n_accum_x;
            r_accum_y <= n_accum_y;
        end
    end
endmodule

>>> rtl/core/trackball_motion_to_report.sv
// Top level of the trackball motion to report block.
// This block takes one item per clock cycle, set by the single-pass accumulator update, while
// no report request waits for the output. An item is held in an input register, then updates
// the two motion accumulators; a report request puts its report into the output register, so
// a report passes the input and then the output register. Motion items continue while a
// report waits at the output; a second report request waits in the input register until the
// pending report is taken. Configuration writes take effect on the next cycle.
module trackball_motion_to_report (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tmr_in_if.sink            i_item,
    tmr_out_if.source         o_report,
    input  logic              i_cfg_we,
    input  tmr_pkg::t_cfg_idx i_cfg_idx,
    input  logic [2:0]        i_cfg_data
);
    import tmr_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_report result;
    t_report r_out;
    logic    r_out_valid;
    logic    out_free;
    logic    fire;

    assign out_free = !r_out_valid || o_report.ready;
    assign fire = r_in_valid && ((r_in.opcode == OP_MOTION) || out_free);
    assign i_item.ready = !r_in_valid || fire;

    tmr_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tmr_report_core u_report_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_report (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.opcode        <= i_item.opcode;
            r_in.delta_x       <= i_item.delta_x;
            r_in.delta_y       <= i_item.delta_y;
            r_in.scroll_active <= i_item.scroll_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && (r_in.opcode == OP_REPORT)) begin
            r_out_valid <= 1'b1;
        end else if (o_report.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (r_in.opcode == OP_REPORT)) begin
            r_out <= result;
        end
    end

    assign o_report.valid   = r_out_valid;
    assign o_report.move_x  = r_out.move_x;
    assign o_report.move_y  = r_out.move_y;
    assign o_report.wheel_h = r_out.wheel_h;
    assign o_report.wheel_v = r_out.wheel_v;
endmodule

>>> rtl/core/tmr_checker.sv
// Port checker of the trackball motion to report block and its bind statement.
module tmr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic signed [7:0] i_move_x,
    input logic signed [7:0] i_move_y,
    input logic signed [7:0] i_wheel_h,
    input logic signed [7:0] i_wheel_v
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("Report valid did not clear after reset.");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("Report item dropped while stalled.");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_move_x) && $stable(i_move_y)
            && $stable(i_wheel_h) && $stable(i_wheel_v))
        else $error("Report payload changed while stalled.");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_move_x != 8'sh80 && i_move_y != 8'sh80
            && i_wheel_h != 8'sh80 && i_wheel_v != 8'sh80)
        else $error("Report field outside of plus or minus 127.");

    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_move_x != 8'sd0 || i_move_y != 8'sd0)
            |-> i_wheel_h == 8'sd0 && i_wheel_v == 8'sd0)
        else $error("Report carries both pointer and wheel motion.");
endmodule

bind trackball_motion_to_report tmr_checker u_tmr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_report.valid),
    .i_ready   (o_report.ready),
    .i_move_x  (o_report.move_x),
    .i_move_y  (o_report.move_y),
    .i_wheel_h (o_report.wheel_h),
    .i_wheel_v (o_report.wheel_v)
);

>>> verif/tb_top.sv
// Self-checking testbench of the trackball motion to report block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmr_pkg::*;

    localparam int STUCK_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int N_PHASES        = 8;
    localparam int N_FIXED_CFG     = 5;
    localparam int N_ROWS          = 23;

    localparam logic [1:0] SNAP_FREE     = 2'd2;
    localparam logic [1:0] SNAP_FREE_ALT = 2'd3;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_report want;
    } t_row;

    localparam t_row DIR_TAB [0:N_ROWS-1] = '{
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b1}, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{'{OP_MOTION, SAT_MAX, SAT_MIN, 1'b1}, 1'b0, '0},
        '{'{OP_MOTION, 16'sd1, -16'sd1, 1'b0}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{-8'sd127, 8'sd127, 8'sd0, 8'sd0}},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{'{OP_MOTION, SAT_MIN, SAT_MAX, 1'b0}, 1'b0, '0},
        '{'{OP_MOTION, -16'sd1, 16'sd1, 1'b1}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
        '{'{OP_MOTION, 16'sd100, -16'sd100, 1'b0}, 1'b0, '0},
        '{'{OP_MOTION, 16'sd27, -16'sd27, 1'b0}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{-8'sd127, 8'sd127, 8'sd0, 8'sd0}},
        '{'{OP_MOTION, 16'sd128, -16'sd128, 1'b0}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{-8'sd127, 8'sd127, 8'sd0, 8'sd0}},
        '{'{OP_MOTION, -16'sd7, 16'sd7, 1'b0}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b1}, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{'{OP_MOTION, -16'sd1, 16'sd1, 1'b1}, 1'b0, '0},
        '{'{OP_REPORT, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0},
        '{'{OP_MOTION, 16'sh5555, 16'shAAAA, 1'b0}, 1'b0, '0},
        '{'{OP_MOTION, 16'shAAAA, 16'sh5555, 1'b1}, 1'b0, '0},
        '{'{OP_REPORT, 16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0},
        '{'{OP_REPORT, 16'shFFFF, 16'sh0001, 1'b1}, 1'b0, '0}
    };

    localparam t_cfg FIXED_CFG [0:N_FIXED_CFG-1] = '{
        '{3'd1, SNAP_FREE, 1'b0},
        '{3'd7, SNAP_VERTICAL, 1'b1},
        '{3'd0, SNAP_FREE_ALT, 1'b1},
        '{3'd4, SNAP_HORIZONTAL, 1'b0},
        '{3'd2, SNAP_FREE, 1'b1}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [2:0]  i_cfg_data;

    tmr_in_if  in_ch ();
    tmr_out_if out_ch ();

    trackball_motion_to_report uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch.sink),
        .o_report   (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [2:0]         div_exp   = DIV_DEFAULT;
    logic [1:0]         snap      = SNAP_VERTICAL;
    logic               left_side = 1'b0;
    logic signed [15:0] acc_x     = '0;
    logic signed [15:0] acc_y     = '0;

    t_report report_q [$];
    int      err_cnt     = 0;
    int      hold_asks   = 0;
    int      stuck_count = 0;

    function automatic logic signed [15:0] sat16(input int v);
        if (v > int'(SAT_MAX)) return SAT_MAX;
        if (v < int'(SAT_MIN)) return SAT_MIN;
        return 16'(v);
    endfunction

    function automatic int clip127(input int v);
        if (v > int'(CLIP_MAX)) return int'(CLIP_MAX);
        if (v < int'(CLIP_MIN)) return int'(CLIP_MIN);
        return v;
    endfunction

    // Updates the accumulators and returns 1 when the item produces a report.
    function automatic bit form_report(input t_item it, output t_report rep);
        int mx, my, h, v, e, d, qx, qy;
        rep = '0;
        if (it.opcode == OP_MOTION) begin
            acc_x = sat16(int'(acc_x) + int'(it.delta_x));
            acc_y = sat16(int'(acc_y) + int'(it.delta_y));
            return 1'b0;
        end
        if (!it.scroll_active) begin
            mx = clip127(int'(acc_y));
            my = clip127(int'(acc_x));
            if (left_side) begin
                mx = -mx;
                my = -my;
            end
            acc_x = '0;
            acc_y = '0;
            rep.move_x = 8'(mx);
            rep.move_y = 8'(my);
        end else begin
            e  = (div_exp == 3'd0) ? int'(DIV_DEFAULT) : int'(div_exp);
            d  = 1 << (e - 1);
            qx = int'(acc_x) / d;
            qy = int'(acc_y) / d;
            acc_x = 16'(int'(acc_x) - qx * d);
            acc_y = 16'(int'(acc_y) - qy * d);
            h = clip127(qy);
            v = -clip127(qx);
            if (left_side) begin
                h = -h;
                v = -v;
            end
            if (snap == SNAP_VERTICAL) begin
                h = 0;
            end else if (snap == SNAP_HORIZONTAL) begin
                v = 0;
            end
            rep.wheel_h = 8'(-h);
            rep.wheel_v = 8'(-v);
        end
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] rand_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 16'(int'($urandom_range(0, 400)) - 200);
        if (r < 75) return 16'(int'($urandom_range(0, 6000)) - 3000);
        if (r < 92) return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_report typed_rep);
        t_report rep;
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= it.opcode;
        in_ch.delta_x       <= it.delta_x;
        in_ch.delta_y       <= it.delta_y;
        in_ch.scroll_active <= it.scroll_active;
        do @(posedge i_clk); while (!in_ch.ready);
        if (form_report(it, rep)) begin
            report_q.push_back(typed ? typed_rep : rep);
        end
    endtask

    task automatic sender_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid         <= 1'b0;
            in_ch.opcode        <= 1'($urandom);
            in_ch.delta_x       <= 16'($urandom);
            in_ch.delta_y       <= 16'($urandom);
            in_ch.scroll_active <= 1'($urandom);
        end
    endtask

    task automatic wait_drained();
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [2:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SCROLL_DIVIDER: div_exp = data;
            CFG_SNAP_MODE:      snap = data[1:0];
            CFG_LEFT_HALF:      left_side = data[0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string fname, input logic signed [7:0] want_v,
                               input logic signed [7:0] got_v);
        if (got_v !== want_v) begin
            err_cnt++;
            $display("%0t ns: %s expected %0d, got %0d", $time, fname, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_report want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (report_q.size() == 0) begin
                err_cnt++;
                $display("%0t ns: report expected none, got %0d %0d %0d %0d", $time,
                         out_ch.move_x, out_ch.move_y, out_ch.wheel_h, out_ch.wheel_v);
            end else begin
                want = report_q.pop_front();
                check_field("move_x", want.move_x, out_ch.move_x);
                check_field("move_y", want.move_y, out_ch.move_y);
                check_field("wheel_h", want.wheel_h, out_ch.wheel_h);
                check_field("wheel_v", want.wheel_v, out_ch.wheel_v);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_count = 0;
        end else begin
            stuck_count++;
        end
        if (stuck_count >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : receiver
        int rx_cycle;
        int rx_mode;
        int hold_seen;
        int hold_left;
        rx_cycle  = 0;
        rx_mode   = 0;
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom);
                    2: out_ch.ready <= (rx_cycle % 4 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_item it;
        t_cfg  cfg;
        bit    gappy;
        int    report_pct;
        int    burst_left;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_SCROLL_DIVIDER;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= OP_MOTION;
        in_ch.delta_x       <= '0;
        in_ch.delta_y       <= '0;
        in_ch.scroll_active <= 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 3));
            send_item(DIR_TAB[r].it, DIR_TAB[r].typed, DIR_TAB[r].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            sender_gap(1);
            wait_drained();
            repeat (4) @(posedge i_clk);
            if (ph < N_FIXED_CFG) begin
                cfg = FIXED_CFG[ph];
                cfg_write(CFG_SCROLL_DIVIDER, cfg.scroll_divider);
                cfg_write(CFG_SNAP_MODE, {1'b0, cfg.snap_mode});
                cfg_write(CFG_LEFT_HALF, {2'b00, cfg.left_half});
            end else begin
                cfg_write(CFG_SCROLL_DIVIDER, 3'($urandom));
                cfg_write(CFG_SNAP_MODE, 3'($urandom));
                cfg_write(CFG_LEFT_HALF, 3'($urandom));
            end
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            gappy      = ($urandom_range(0, 3) != 0);
            report_pct = (ph == 2) ? 50 : $urandom_range(10, 40);
            if (ph == 2) hold_asks++;
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 4 && n == ITEMS_PER_PHASE / 2) begin
                    sender_gap(1);
                    wait_drained();
                end
                if (burst_left == 0) begin
                    if (gappy) sender_gap($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 24);
                end
                it.opcode        = ($urandom_range(0, 99) < report_pct) ? OP_REPORT : OP_MOTION;
                it.delta_x       = rand_delta();
                it.delta_y       = rand_delta();
                it.scroll_active = 1'($urandom);
                send_item(it, 1'b0, '0);
                burst_left--;
            end
        end

        sender_gap(1);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tmr_pkg.sv
rtl/core/tmr_in_if.sv
rtl/core/tmr_out_if.sv
rtl/core/tmr_cfg_regs.sv
rtl/core/tmr_report_core.sv
rtl/core/trackball_motion_to_report.sv
rtl/core/tmr_checker.sv
verif/tb_top.sv
